@@ design/mbps_pkg.sv @@
// ----------------------------------------------------------------------------
// mbps_pkg: shared types and constants of the masked byte pattern scanner
// Sizes, register indexes, result kinds and the result record.
// ----------------------------------------------------------------------------
package mbps_pkg;

    localparam int PATTERN_MAX = 32;
    localparam int OFFSET_BITS = 32;
    localparam int PAT_LIMIT   = (PATTERN_MAX < 32) ? PATTERN_MAX : 32;
    localparam int FILL_W      = $clog2(PATTERN_MAX + 1);
    localparam int LEN_W       = 6;
    localparam int OFS_W       = 32;
    localparam int TOTAL_W     = 16;
    localparam int ADDR_W      = 6;
    localparam int DATA_W      = 64;

    localparam int RQ_DEPTH    = 4;
    localparam int RQ_PTR_W    = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W    = $clog2(RQ_DEPTH + 1);

    typedef enum logic [2:0] {
        REG_PAT0 = 3'd0,
        REG_PAT1 = 3'd1,
        REG_PAT2 = 3'd2,
        REG_PAT3 = 3'd3,
        REG_MASK = 3'd4,
        REG_LEN  = 3'd5,
        REG_HINT = 3'd6
    } t_reg_idx;

    localparam logic KIND_MATCH   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic               result_kind;
        logic [OFS_W-1:0]   match_offset;
        logic               found;
        logic               hint_correct;
        logic [TOTAL_W-1:0] match_total;
        logic               last_result;
    } t_result;

    // up to two results per byte; b only ever follows a
    typedef struct packed {
        logic    a_valid;
        t_result a;
        logic    b_valid;
        t_result b;
    } t_rq_push;

endpackage

@@ design/mbps_if.sv @@
// ----------------------------------------------------------------------------
// mbps_if: valid/ready channels of the masked byte pattern scanner
// Byte channel in, result channel out.
// ----------------------------------------------------------------------------
interface mbps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mbps_out_if
    import mbps_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic [OFS_W-1:0]   match_offset;
    logic               found;
    logic               hint_correct;
    logic [TOTAL_W-1:0] match_total;
    logic               last_result;

    modport source (output valid, output result_kind, output match_offset, output found,
                    output hint_correct, output match_total, output last_result,
                    input ready);
    modport sink   (input valid, input result_kind, input match_offset, input found,
                    input hint_correct, input match_total, input last_result,
                    output ready);
endinterface

@@ design/mbps_cell.sv @@
// ----------------------------------------------------------------------------
// mbps_cell: one window cell
// Holds one window byte, passes it on at each shift, compares it with the
// pattern byte aligned to this cell.
// ----------------------------------------------------------------------------
module mbps_cell
    import mbps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_shift,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_pat_byte,
    input  logic       i_care,
    output logic [7:0] o_byte,
    output logic       o_hit
);

    logic [7:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;
    assign o_hit  = !i_care || (r_byte == i_pat_byte);

endmodule

@@ design/mbps_rq.sv @@
// ----------------------------------------------------------------------------
// mbps_rq: result queue
// Small queue taking up to two results a cycle and giving one per transfer.
// ----------------------------------------------------------------------------
module mbps_rq
    import mbps_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_rq_push i_push,
    output logic     o_room,
    output logic     o_valid,
    input  logic     i_ready,
    output t_result  o_data
);

    t_result             r_mem [RQ_DEPTH];
    logic [RQ_PTR_W-1:0] r_wr;
    logic [RQ_PTR_W-1:0] r_rd;
    logic [RQ_CNT_W-1:0] r_cnt;
    logic [RQ_PTR_W-1:0] n_wr;
    logic [RQ_CNT_W-1:0] n_cnt;
    logic [RQ_PTR_W-1:0] wr_b;
    logic [1:0]          push_n;
    logic                pop;

    assign pop    = o_valid && i_ready;
    assign push_n = 2'(i_push.a_valid) + 2'(i_push.b_valid);
    assign wr_b   = r_wr + RQ_PTR_W'(1);
    assign n_wr   = r_wr + RQ_PTR_W'(push_n);
    assign n_cnt  = r_cnt + RQ_CNT_W'(push_n) - RQ_CNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_cnt <= n_cnt;
            if (pop) begin
                r_rd <= r_rd + RQ_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.a_valid) begin
            r_mem[r_wr] <= i_push.a;
        end
        if (i_push.b_valid) begin
            r_mem[wr_b] <= i_push.b;
        end
    end

    // room for a full pair, regardless of this cycle's pop
    assign o_room  = r_cnt <= RQ_CNT_W'(RQ_DEPTH - 2);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rd];

endmodule

@@ design/masked_byte_pattern_scanner_unit.sv @@
// A byte's result is registered in the compare stage, then written to the result queue, before it is offered.
// Throughput: one byte per cycle while the result queue has room; the output port moves one
// result per cycle, so a byte that both matches and ends the image takes two output transfers.
// The result queue (4 entries) sets how far output stalls are absorbed before input waits.
// Reset: synchronous, active low; clears registers to their defaults (length 1) and scan state.
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner_unit: wildcard byte pattern search
// Streams image bytes through a row of window cells, compares the window with
// a masked pattern, reports each match and an end-of-image summary.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner_unit
    import mbps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    mbps_in_if.sink           i_in,
    mbps_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // ------------------------------------------------------------------
    // Register file. Each register sits at 8*index; low address bits
    // are ignored.
    // ------------------------------------------------------------------
    logic [63:0]      r_pat [4];
    logic [31:0]      r_mask;
    logic [LEN_W-1:0] r_len;
    logic [31:0]      r_hint;
    logic             cfg_wr;
    t_reg_idx         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[5:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat[0] <= '0;
            r_pat[1] <= '0;
            r_pat[2] <= '0;
            r_pat[3] <= '0;
            r_mask   <= '0;
            r_len    <= LEN_W'(1);
            r_hint   <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_PAT0: r_pat[0] <= pwdata;
                REG_PAT1: r_pat[1] <= pwdata;
                REG_PAT2: r_pat[2] <= pwdata;
                REG_PAT3: r_pat[3] <= pwdata;
                REG_MASK: r_mask   <= pwdata[31:0];
                REG_LEN:  r_len    <= pwdata[LEN_W-1:0];
                REG_HINT: r_hint   <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_PAT0: prdata = r_pat[0];
            REG_PAT1: prdata = r_pat[1];
            REG_PAT2: prdata = r_pat[2];
            REG_PAT3: prdata = r_pat[3];
            REG_MASK: prdata = DATA_W'(r_mask);
            REG_LEN:  prdata = DATA_W'(r_len);
            REG_HINT: prdata = DATA_W'(r_hint);
            default:  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Effective length: zero acts as one, anything past the limit is
    // clipped to it.
    // ------------------------------------------------------------------
    logic [LEN_W-1:0] len_eff;

    always_comb begin
        if (r_len == '0) begin
            len_eff = LEN_W'(1);
        end else if (r_len > LEN_W'(PAT_LIMIT)) begin
            len_eff = LEN_W'(PAT_LIMIT);
        end else begin
            len_eff = r_len;
        end
    end

    // ------------------------------------------------------------------
    // Pattern aligned to the window. Cell k holds the byte k places back,
    // which lines up with pattern byte len-1-k. Cells at or beyond the
    // length never take part.
    // ------------------------------------------------------------------
    logic [255:0]     pat_flat;
    logic [7:0]       cell_pat  [PATTERN_MAX];
    logic             cell_care [PATTERN_MAX];

    assign pat_flat = {r_pat[3], r_pat[2], r_pat[1], r_pat[0]};

    always_comb begin
        logic [LEN_W-1:0] j;
        j = '0;
        for (int k = 0; k < PATTERN_MAX; k++) begin
            if ((k < PAT_LIMIT) && (LEN_W'(k) < len_eff)) begin
                j            = LEN_W'(len_eff - LEN_W'(k) - LEN_W'(1));
                cell_care[k] = !r_mask[j[4:0]];
                cell_pat[k]  = pat_flat[j[4:0]*8 +: 8];
            end else begin
                cell_care[k] = 1'b0;
                cell_pat[k]  = '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input stage: a transfer shifts the window cells and captures the
    // byte's offset and the window fill into the compare stage.
    // ------------------------------------------------------------------
    logic                   in_go;
    logic                   s1_go;
    logic                   rq_room;
    logic                   r_s1_valid;
    logic                   r_s1_last;
    logic [OFFSET_BITS-1:0] r_s1_pos;
    logic [FILL_W-1:0]      r_s1_fill;
    logic [OFFSET_BITS-1:0] r_pos;
    logic [FILL_W-1:0]      r_fill;
    logic [FILL_W-1:0]      fill_inc;

    assign s1_go       = r_s1_valid && rq_room;
    assign i_in.ready  = !r_s1_valid || s1_go;
    assign in_go       = i_in.valid && i_in.ready;
    assign fill_inc    = (r_fill == FILL_W'(PATTERN_MAX)) ? r_fill : r_fill + FILL_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_pos      <= '0;
            r_fill     <= '0;
        end else begin
            if (in_go) begin
                r_s1_valid <= 1'b1;
                // the byte after the last one opens a fresh image
                r_pos      <= i_in.last_byte ? '0 : r_pos + OFFSET_BITS'(1);
                r_fill     <= i_in.last_byte ? '0 : fill_inc;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_go) begin
            r_s1_last <= i_in.last_byte;
            r_s1_pos  <= r_pos;
            r_s1_fill <= fill_inc;
        end
    end

    // ------------------------------------------------------------------
    // Window cells
    // ------------------------------------------------------------------
    logic [7:0]             cell_byte [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] hits;

    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
        mbps_cell u_cell (
            .i_clk      (i_clk),
            .i_shift    (in_go),
            .i_byte     ((k == 0) ? i_in.data_byte : cell_byte[(k == 0) ? 0 : k-1]),
            .i_pat_byte (cell_pat[k]),
            .i_care     (cell_care[k]),
            .o_byte     (cell_byte[k]),
            .o_hit      (hits[k])
        );
    end

    // ------------------------------------------------------------------
    // Compare stage: match decision, per-image tracking, result build.
    // ------------------------------------------------------------------
    logic                   r_found;
    logic [OFFSET_BITS-1:0] r_first;
    logic                   r_hhit;
    logic [TOTAL_W-1:0]     r_cnt;
    logic                   n_found;
    logic [OFFSET_BITS-1:0] n_first;
    logic                   n_hhit;
    logic [TOTAL_W-1:0]     n_cnt;
    logic                   fits;
    logic                   match;
    logic [OFFSET_BITS-1:0] start;
    logic [63:0]            start64;
    logic [63:0]            first64;
    logic                   at_hint;
    t_result                rep;
    t_result                summ;
    t_rq_push               push;

    assign fits    = 32'(r_s1_fill) >= 32'(len_eff);
    assign match   = fits && (&hits);
    assign start   = r_s1_pos - OFFSET_BITS'(len_eff - LEN_W'(1));
    assign start64 = 64'(start);
    assign at_hint = start64 == 64'(r_hint);

    assign n_found = r_found || match;
    assign n_first = (!r_found && match) ? start : r_first;
    assign n_hhit  = r_hhit || (match && at_hint);
    assign n_cnt   = (match && (r_cnt != '1)) ? r_cnt + TOTAL_W'(1) : r_cnt;
    assign first64 = 64'(n_first);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_first <= '0;
            r_hhit  <= 1'b0;
            r_cnt   <= '0;
        end else if (s1_go) begin
            if (r_s1_last) begin
                r_found <= 1'b0;
                r_first <= '0;
                r_hhit  <= 1'b0;
                r_cnt   <= '0;
            end else begin
                r_found <= n_found;
                r_first <= n_first;
                r_hhit  <= n_hhit;
                r_cnt   <= n_cnt;
            end
        end
    end

    always_comb begin
        rep.result_kind  = KIND_MATCH;
        rep.match_offset = start64[OFS_W-1:0];
        rep.found        = 1'b1;
        rep.hint_correct = at_hint;
        rep.match_total  = n_cnt;
        rep.last_result  = !r_s1_last;

        // hint wins when it matched; otherwise first match, zero if none
        summ.result_kind  = KIND_SUMMARY;
        summ.match_offset = n_hhit ? r_hint : first64[OFS_W-1:0];
        summ.found        = n_found;
        summ.hint_correct = n_hhit;
        summ.match_total  = n_cnt;
        summ.last_result  = 1'b1;

        push.a_valid = s1_go && (match || r_s1_last);
        push.a       = match ? rep : summ;
        push.b_valid = s1_go && match && r_s1_last;
        push.b       = summ;
    end

    // ------------------------------------------------------------------
    // Result queue and output channel
    // ------------------------------------------------------------------
    t_result rq_data;
    logic    rq_valid;

    mbps_rq u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (rq_room),
        .o_valid (rq_valid),
        .i_ready (o_out.ready),
        .o_data  (rq_data)
    );

    assign o_out.valid        = rq_valid;
    assign o_out.result_kind  = rq_data.result_kind;
    assign o_out.match_offset = rq_data.match_offset;
    assign o_out.found        = rq_data.found;
    assign o_out.hint_correct = rq_data.hint_correct;
    assign o_out.match_total  = rq_data.match_total;
    assign o_out.last_result  = rq_data.last_result;

endmodule

@@ design/mbps_chk.sv @@
// ----------------------------------------------------------------------------
// mbps_chk: port checker for the masked byte pattern scanner
// Watches the result channel for stall stability and result consistency.
// ----------------------------------------------------------------------------
module mbps_chk
    import mbps_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               i_ready,
    input logic               i_kind,
    input logic [OFS_W-1:0]   i_ofs,
    input logic               i_found,
    input logic               i_hc,
    input logic [TOTAL_W-1:0] i_total,
    input logic               i_last
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid &&
            $stable({i_kind, i_ofs, i_found, i_hc, i_total, i_last}))
        else $error("result changed while stalled");

    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind == KIND_SUMMARY) |-> i_last)
        else $error("summary not marked as final result");

    a_report_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind == KIND_MATCH) |-> i_found && (i_total != '0))
        else $error("match report without count");

    a_empty_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind == KIND_SUMMARY) && !i_found |-> (i_ofs == '0) && !i_hc)
        else $error("summary without match carries offset or hint");

endmodule

bind masked_byte_pattern_scanner_unit mbps_chk u_mbps_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out.valid),
    .i_ready (o_out.ready),
    .i_kind  (o_out.result_kind),
    .i_ofs   (o_out.match_offset),
    .i_found (o_out.found),
    .i_hc    (o_out.hint_correct),
    .i_total (o_out.match_total),
    .i_last  (o_out.last_result)
);

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the masked byte pattern scanner
// Streams byte images through the block under random source gaps and sink
// stalls, predicts every match report and end-of-image summary, and compares
// each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import mbps_pkg::*;

    localparam int     CYCLE_LIMIT = 800000;
    localparam int     LONG_HOLD   = 200;
    localparam int     SETTLE      = 8;     // length of the closing quiet spell in settle()
    localparam int     RANDOM_ITEMS = 480;
    localparam logic [63:0] OFS_MASK = (64'd1 << OFFSET_BITS) - 64'd1;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_scan_byte;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    always #6 i_clk = ~i_clk;

    // configuration port, idle from time zero
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    mbps_in_if  in_ch ();
    mbps_out_if out_ch ();

    masked_byte_pattern_scanner_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Shadow of the register file (reset values) and of the scan state
    // ------------------------------------------------------------------
    logic [63:0] pat_words [4] = '{default: 64'd0};
    logic [31:0] wc_mask  = '0;
    logic [5:0]  pat_len  = 6'd1;
    logic [31:0] hint_ofs = '0;

    logic [7:0]  win [PATTERN_MAX] = '{default: 8'd0};  // win[0] is the newest byte
    int          win_fill  = 0;
    logic [63:0] scan_pos  = '0;
    bit          seen_any  = 1'b0;
    logic [63:0] first_ofs = '0;
    bit          hint_seen = 1'b0;
    logic [15:0] hit_count = '0;

    t_result     pending_results [$];
    t_scan_byte  byte_feed [$];

    int mismatches = 0;
    int cycle_count = 0;

    // idling controls, set per phase by the stimulus process
    bit feed_gaps_on    = 1'b1;
    bit drain_stalls_on = 1'b1;
    int hold_req  = 0;
    int hold_seen = 0;
    int hold_left = 0;

    // length actually compared: 0 acts as 1, anything above the limit is clipped
    function automatic int used_len();
        int n;
        n = int'(pat_len);
        if (n < 1) n = 1;
        if (n > PAT_LIMIT) n = PAT_LIMIT;
        return n;
    endfunction

    function automatic logic [7:0] pat_byte(input int j);
        return pat_words[j >> 3][(j % 8) * 8 +: 8];
    endfunction

    function automatic int draw_gap(input bit on);
        int r;
        if (!on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Works out the results of one accepted byte and queues them.
    function automatic void predict_scan(input logic [7:0] b, input logic last);
        int          len;
        int          j;
        bit          hit;
        logic [63:0] start;
        t_result     r;

        len = used_len();
        for (j = PATTERN_MAX - 1; j > 0; j--) win[j] = win[j-1];
        win[0] = b;
        if (win_fill < PATTERN_MAX) win_fill++;

        // oldest window byte lines up with pattern byte 0
        hit = (win_fill >= len);
        for (j = 0; j < len && hit; j++)
            if (!wc_mask[j] && pat_byte(j) != win[len-1-j]) hit = 1'b0;

        if (hit) begin
            start = (scan_pos - 64'(len - 1)) & OFS_MASK;
            if (!seen_any) begin
                seen_any  = 1'b1;
                first_ofs = start;
            end
            if (start == 64'(hint_ofs)) hint_seen = 1'b1;
            if (hit_count != 16'hFFFF) hit_count++;
            r.result_kind  = KIND_MATCH;
            r.match_offset = start[OFS_W-1:0];
            r.found        = 1'b1;
            r.hint_correct = (start == 64'(hint_ofs));
            r.match_total  = hit_count;
            r.last_result  = !last;
            pending_results.insert(pending_results.size(), r);
        end

        scan_pos = (scan_pos + 64'd1) & OFS_MASK;

        if (last) begin
            r.result_kind  = KIND_SUMMARY;
            r.match_offset = hint_seen ? hint_ofs : (seen_any ? first_ofs[OFS_W-1:0] : '0);
            r.found        = seen_any;
            r.hint_correct = hint_seen;
            r.match_total  = hit_count;
            r.last_result  = 1'b1;
            pending_results.insert(pending_results.size(), r);
            // per-image state back to reset
            win       = '{default: 8'd0};
            win_fill  = 0;
            scan_pos  = '0;
            seen_any  = 1'b0;
            first_ofs = '0;
            hint_seen = 1'b0;
            hit_count = '0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Byte source: offers queued bytes, with random gaps between transfers
    // ------------------------------------------------------------------
    int gap_left = 0;

    always @(posedge i_clk) begin : byte_source
        t_scan_byte nxt;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            gap_left    <= 0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (gap_left != 0) begin
                in_ch.valid <= 1'b0;
                gap_left    <= gap_left - 1;
            end else if (byte_feed.size() != 0) begin
                nxt = byte_feed.pop_front();
                in_ch.valid     <= 1'b1;
                in_ch.data_byte <= nxt.data;
                in_ch.last_byte <= nxt.last;
                gap_left        <= draw_gap(feed_gaps_on);
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Long hold-off of the result sink, counted here; armed by bumping hold_req.
    always @(posedge i_clk) begin : long_hold
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_seen <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_req) begin
            hold_left <= LONG_HOLD;
            hold_seen <= hold_req;
        end
    end

    // Result sink: random stalls, plus the long hold-off above
    int stall_left = 0;

    always @(posedge i_clk) begin : result_sink
        int s;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left   <= 0;
        end else if (stall_left != 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else begin
            s = draw_gap(drain_stalls_on);
            out_ch.ready <= (hold_left == 0) && (s == 0);
            stall_left   <= (s != 0) ? s - 1 : 0;
        end
    end

    // ------------------------------------------------------------------
    // Checker: result transfers against the oldest prediction, then the
    // prediction for any byte transferred at this same edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : scoreboard
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got.result_kind  = out_ch.result_kind;
                got.match_offset = out_ch.match_offset;
                got.found        = out_ch.found;
                got.hint_correct = out_ch.hint_correct;
                got.match_total  = out_ch.match_total;
                got.last_result  = out_ch.last_result;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: kind=%0d ofs=%0h found=%0d hint=%0d total=%0d last=%0d",
                                 got.result_kind, got.match_offset, got.found,
                                 got.hint_correct, got.match_total, got.last_result);
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result mismatch at cycle %0d", cycle_count);
                            $display("  expected kind=%0d ofs=%0h found=%0d hint=%0d total=%0d last=%0d",
                                     want.result_kind, want.match_offset, want.found,
                                     want.hint_correct, want.match_total, want.last_result);
                            $display("  actual   kind=%0d ofs=%0h found=%0d hint=%0d total=%0d last=%0d",
                                     got.result_kind, got.match_offset, got.found,
                                     got.hint_correct, got.match_total, got.last_result);
                        end
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                predict_scan(in_ch.data_byte, in_ch.last_byte);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // setup then access cycle; the register takes the value at the access edge
    task automatic reg_write(input t_reg_idx idx, input logic [63:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(8 * int'(idx));
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PAT0, REG_PAT1, REG_PAT2, REG_PAT3: pat_words[int'(idx)] = val;
            REG_MASK: wc_mask  = val[31:0];
            REG_LEN:  pat_len  = val[5:0];
            REG_HINT: hint_ofs = val[31:0];
            default: ;
        endcase
    endtask

    task automatic push_byte(input logic [7:0] d, input logic last);
        t_scan_byte it;
        it.data = d;
        it.last = last;
        byte_feed.insert(byte_feed.size(), it);
    endtask

    // bytes listed first-to-last from the top of the literal
    task automatic feed_bytes(input logic [255:0] seq, input int n, input bit close);
        int k;
        for (k = 0; k < n; k++)
            push_byte(seq[8*(n-1-k) +: 8], close && (k == n - 1));
    endtask

    // All bytes transferred, every result in, then a short quiet spell so that
    // bytes with no result have left the pipeline before the next register write.
    task automatic settle();
        @(posedge i_clk);
        while (byte_feed.size() != 0 || in_ch.valid) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [63:0] pick_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return 64'd0;
        if (r < 30) return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)  return 64'd0;
        if (r < 18) return 64'd1;
        if (r < 55) return 64'($urandom_range(2, 4));
        if (r < 75) return 64'($urandom_range(5, 8));
        if (r < 85) return 64'($urandom_range(9, 31));
        if (r < 93) return 64'd32;
        return 64'($urandom_range(33, 63));
    endfunction

    task automatic random_setup();
        int r;
        reg_write(REG_PAT0, pick_word());
        reg_write(REG_PAT1, pick_word());
        reg_write(REG_PAT2, pick_word());
        reg_write(REG_PAT3, pick_word());
        r = $urandom_range(0, 99);
        if (r < 30)      reg_write(REG_MASK, 64'd0);
        else if (r < 38) reg_write(REG_MASK, 64'hFFFF_FFFF);
        else             reg_write(REG_MASK, 64'($urandom & $urandom & $urandom));
        reg_write(REG_LEN, pick_len());
        r = $urandom_range(0, 99);
        if (r < 15)      reg_write(REG_HINT, 64'd0);
        else if (r < 25) reg_write(REG_HINT, 64'hFFFF_FFFF);
        else             reg_write(REG_HINT, 64'($urandom_range(0, 60)));
    endtask

    // One image: planted pattern copies (wildcards filled at random) between
    // noise bytes, half of which are borrowed from the pattern for near misses.
    task automatic random_image(input int n_bytes, input bit close, inout int sent);
        logic [7:0] img [$];
        int len;
        int j;
        len = used_len();
        while (img.size() < n_bytes) begin
            if ($urandom_range(0, 99) < 35 && img.size() + len <= n_bytes) begin
                for (j = 0; j < len; j++)
                    img.insert(img.size(), wc_mask[j] ? 8'($urandom) : pat_byte(j));
            end else if ($urandom_range(0, 1) != 0) begin
                img.insert(img.size(), 8'($urandom));
            end else begin
                img.insert(img.size(), pat_byte($urandom_range(0, len - 1)));
            end
        end
        for (j = 0; j < img.size(); j++)
            push_byte(img[j], close && (j == img.size() - 1));
        sent += img.size();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int sent;
        int n_img;
        int i;
        int len;
        int n;

        in_ch.valid     = 1'b0;
        in_ch.data_byte = 8'd0;
        in_ch.last_byte = 1'b0;
        out_ch.ready    = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: length 1, pattern byte zero, hint at 0
        feed_bytes(256'h00_FF_00, 3, 1'b1);
        settle();

        // Wildcard in the second byte; two matches, the later one on the hint
        reg_write(REG_PAT0, 64'h0000_0000_EFBE_ADDE);
        reg_write(REG_MASK, 64'h2);
        reg_write(REG_LEN,  64'd4);
        reg_write(REG_HINT, 64'd5);
        feed_bytes(256'h11_DE_55_BE_EF_DE_AD_BE_EF, 9, 1'b1);
        settle();

        // Length 0 acts as 1; hint beyond the image never hits
        reg_write(REG_PAT0, '1);
        reg_write(REG_MASK, 64'd0);
        reg_write(REG_LEN,  64'd0);
        reg_write(REG_HINT, 64'hFFFF_FFFF);
        feed_bytes(256'hFF_00_FF, 3, 1'b1);
        settle();

        // Image shorter than the pattern, then an image with no match at all
        reg_write(REG_PAT0, 64'd0);
        reg_write(REG_LEN,  64'd4);
        reg_write(REG_HINT, 64'd1);
        feed_bytes(256'h00_00, 2, 1'b1);
        feed_bytes(256'h01_02_03_04_05, 5, 1'b1);
        settle();

        // Random phases; an image may run on unterminated into the next setup
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            feed_gaps_on    = ($urandom_range(0, 9) < 7);
            drain_stalls_on = ($urandom_range(0, 9) < 7);
            random_setup();
            len   = used_len();
            n_img = $urandom_range(1, 4);
            for (i = 0; i < n_img; i++) begin
                if ($urandom_range(0, 99) < 15) n = $urandom_range(1, len);
                else                            n = $urandom_range(len, 2 * len + 30);
                random_image(n, (i < n_img - 1) || ($urandom_range(0, 99) < 85), sent);
            end
            settle();
        end

        // Every byte matches while the sink holds off: block fills, input waits
        feed_gaps_on    = 1'b0;
        drain_stalls_on = 1'b1;
        reg_write(REG_MASK, 64'h1);
        reg_write(REG_LEN,  64'd1);
        reg_write(REG_HINT, 64'd3);
        hold_req = hold_req + 1;
        random_image(80, 1'b1, sent);
        settle();

        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ masked_byte_pattern_scanner_unit.f @@
design/mbps_pkg.sv
design/mbps_if.sv
design/mbps_cell.sv
design/mbps_rq.sv
design/masked_byte_pattern_scanner_unit.sv
design/mbps_chk.sv
bench/testbench.sv
